// ===== rtl/core/dwta_pkg.sv =====
// Shared types and constants for the winner-take-all subpixel disparity block.
package dwta_pkg;

  localparam int MAX_DISP_DEFAULT  = 256;
  localparam int FRAC_BITS_DEFAULT = 8;
  localparam int ADDR_W            = 4;
  localparam int DATA_W            = 32;

  localparam logic [15:0] COST_ALL_ONES = 16'hFFFF;
  localparam logic [8:0]  RATIO_ONE     = 9'd256;

  localparam logic [1:0] STATUS_VALID      = 2'd0;
  localparam logic [1:0] STATUS_EDGE       = 2'd1;
  localparam logic [1:0] STATUS_NOT_UNIQUE = 2'd2;
  localparam logic [1:0] STATUS_NO_COST    = 2'd3;

  localparam logic [1:0] REG_MIN_DISP   = 2'd0;
  localparam logic [1:0] REG_MAX_DISP   = 2'd1;
  localparam logic [1:0] REG_UNIQ_EN    = 2'd2;
  localparam logic [1:0] REG_UNIQ_RATIO = 2'd3;

  typedef struct packed {
    logic [15:0] cost;
    logic        cost_usable;
  } in_t;

  typedef struct packed {
    logic [15:0] disparity_q8;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic [7:0] disp_first;
    logic [8:0] disp_end;
    logic       uniqueness_enable;
    logic [8:0] uniqueness_ratio_q8;
  } cfg_t;

  typedef struct packed {
    logic acc;
    logic eval;
    logic clr;
    logic out_fail;
    logic dload;
    logic step;
    logic out_fin;
  } cmd_t;

  typedef struct packed {
    logic last_pos;
    logic need_div;
    logic div_last;
  } sts_t;

endpackage

// ===== rtl/core/dwta_regs.sv =====
// Configuration register file behind the APB-style port.
module dwta_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dwta_pkg::ADDR_W-1:0]   paddr,
  input  logic [dwta_pkg::DATA_W-1:0]   pwdata,
  output logic [dwta_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output dwta_pkg::cfg_t                cfg
);
  import dwta_pkg::*;

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[ADDR_W-1:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.disp_first          <= 8'd0;
      cfg.disp_end            <= 9'd64;
      cfg.uniqueness_enable   <= 1'b1;
      cfg.uniqueness_ratio_q8 <= 9'd243;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_MIN_DISP:   cfg.disp_first          <= pwdata[7:0];
        REG_MAX_DISP:   cfg.disp_end            <= pwdata[8:0];
        REG_UNIQ_EN:    cfg.uniqueness_enable   <= pwdata[0];
        REG_UNIQ_RATIO: cfg.uniqueness_ratio_q8 <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_MIN_DISP:   prdata = DATA_W'(cfg.disp_first);
      REG_MAX_DISP:   prdata = DATA_W'(cfg.disp_end);
      REG_UNIQ_EN:    prdata = DATA_W'(cfg.uniqueness_enable);
      REG_UNIQ_RATIO: prdata = DATA_W'(cfg.uniqueness_ratio_q8);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/dwta_ctrl.sv =====
// Sequencer: cost accumulation, pixel evaluation, division and result transfer.
module dwta_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  dwta_pkg::sts_t sts,
  output dwta_pkg::cmd_t cmd
);
  import dwta_pkg::*;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_EVAL,
    ST_DLOAD,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t state;

  assign in_ready = (state == ST_ACC) && (!sts.last_pos || !out_valid || out_ready);

  always_comb begin
    cmd          = '0;
    cmd.acc      = in_valid && in_ready;
    cmd.eval     = (state == ST_EVAL);
    cmd.clr      = (state == ST_EVAL);
    cmd.out_fail = (state == ST_EVAL) && !sts.need_div;
    cmd.dload    = (state == ST_DLOAD);
    cmd.step     = (state == ST_DIV);
    cmd.out_fin  = (state == ST_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_ACC: begin
          if (cmd.acc && sts.last_pos) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (sts.need_div) begin
            state <= ST_DLOAD;
          end else begin
            out_valid <= 1'b1;
            state     <= ST_ACC;
          end
        end
        ST_DLOAD: state <= ST_DIV;
        ST_DIV: begin
          if (sts.div_last) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          out_valid <= 1'b1;
          state     <= ST_ACC;
        end
        default: state <= ST_ACC;
      endcase
    end
  end

endmodule

// ===== rtl/core/dwta_datapath.sv =====
// Cost tracking, status evaluation, serial divider and result register.
module dwta_datapath #(
  parameter int MAX_DISPARITIES = dwta_pkg::MAX_DISP_DEFAULT,
  parameter int FRACTION_BITS   = dwta_pkg::FRAC_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  dwta_pkg::cfg_t cfg,
  input  dwta_pkg::in_t  in_data,
  input  dwta_pkg::cmd_t cmd,
  output dwta_pkg::sts_t sts,
  output dwta_pkg::out_t out_data
);
  import dwta_pkg::*;

  localparam int IW = $clog2(MAX_DISPARITIES);
  localparam int CW = (IW + 1 > 9) ? IW + 1 : 9;
  localparam int MW = 16 + FRACTION_BITS;
  localparam int NW = ((MW > 17) ? MW : 17) + 1;
  localparam int RW = 19;
  localparam int KW = $clog2(NW + 1);
  localparam int BW = ((IW > 8) ? IW : 8) + 1;
  localparam int XW = ((BW + FRACTION_BITS > NW) ? BW + FRACTION_BITS : NW) + 1;

  logic [IW-1:0] position_count, position_count_next;
  logic [15:0]   lowest_cost, lowest_cost_next;
  logic [15:0]   second_cost, second_cost_next;
  logic [IW-1:0] best_index, best_index_next;
  logic [15:0]   previous_cost;
  logic [15:0]   cost_before_best, cost_before_best_next;
  logic [15:0]   cost_after_best, cost_after_best_next;
  logic          await_after, await_after_next;
  logic          seen_usable;

  logic [15:0]   eff_cost;
  logic [8:0]    disp_diff;
  logic [CW-1:0] range_len;
  logic          at_edge;

  logic [8:0]    ratio_c;
  logic [8:0]    weight;
  logic [24:0]   prod;
  logic [16:0]   thresh;
  logic [15:0]   margin;
  logic          not_unique;
  logic [1:0]    status_c;

  logic [16:0]   sum_c;
  logic [16:0]   low2_c;
  logic [16:0]   den_c;
  logic          neg_c;
  logic [15:0]   gap_c;

  logic [16:0]   den_q;
  logic [MW-1:0] mag_q;
  logic          neg_q;
  logic [BW-1:0] base_q;

  logic [NW-1:0] num_q;
  logic [RW-1:0] rem_q;
  logic [17:0]   dsr_q;
  logic [KW-1:0] cnt_q;
  logic [RW-1:0] rem_shift;
  logic          rem_ge;

  logic [XW-1:0] base_s;
  logic [XW-1:0] quot_x;
  logic [XW-1:0] res_x;
  logic [15:0]   disp_fin;

  assign eff_cost  = in_data.cost_usable ? in_data.cost : COST_ALL_ONES;
  assign disp_diff = cfg.disp_end - {1'b0, cfg.disp_first};

  always_comb begin
    if ({1'b0, cfg.disp_first} >= cfg.disp_end) begin
      range_len = CW'(1);
    end else if (CW'(disp_diff) > CW'(MAX_DISPARITIES)) begin
      range_len = CW'(MAX_DISPARITIES);
    end else begin
      range_len = CW'(disp_diff);
    end
  end

  assign sts.last_pos = (CW'(position_count) + CW'(1)) >= range_len;

  always_comb begin
    position_count_next   = position_count + IW'(1);
    lowest_cost_next      = lowest_cost;
    second_cost_next      = second_cost;
    best_index_next       = best_index;
    cost_before_best_next = cost_before_best;
    cost_after_best_next  = cost_after_best;
    await_after_next      = await_after;
    if (await_after) begin
      cost_after_best_next = eff_cost;
      await_after_next     = 1'b0;
    end
    if (in_data.cost_usable) begin
      if (!seen_usable || in_data.cost < lowest_cost) begin
        second_cost_next      = lowest_cost;
        lowest_cost_next      = in_data.cost;
        best_index_next       = position_count;
        cost_before_best_next = (position_count != '0) ? previous_cost : COST_ALL_ONES;
        cost_after_best_next  = COST_ALL_ONES;
        await_after_next      = 1'b1;
      end else if (in_data.cost < second_cost) begin
        second_cost_next = in_data.cost;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      position_count   <= '0;
      lowest_cost      <= COST_ALL_ONES;
      second_cost      <= COST_ALL_ONES;
      best_index       <= '0;
      previous_cost    <= COST_ALL_ONES;
      cost_before_best <= COST_ALL_ONES;
      cost_after_best  <= COST_ALL_ONES;
      await_after      <= 1'b0;
      seen_usable      <= 1'b0;
    end else if (cmd.acc) begin
      position_count   <= position_count_next;
      lowest_cost      <= lowest_cost_next;
      second_cost      <= second_cost_next;
      best_index       <= best_index_next;
      previous_cost    <= eff_cost;
      cost_before_best <= cost_before_best_next;
      cost_after_best  <= cost_after_best_next;
      await_after      <= await_after_next;
      seen_usable      <= seen_usable || in_data.cost_usable;
    end
  end

  assign at_edge = (best_index == '0) || ((CW'(best_index) + CW'(1)) >= range_len);
  assign ratio_c = (cfg.uniqueness_ratio_q8 > RATIO_ONE) ? RATIO_ONE : cfg.uniqueness_ratio_q8;
  assign weight  = RATIO_ONE - ratio_c;
  assign prod    = 25'(lowest_cost) * 25'(weight);
  assign thresh  = prod[24:8];
  assign margin  = second_cost - lowest_cost;
  assign not_unique = cfg.uniqueness_enable && ({1'b0, margin} <= thresh);

  always_comb begin
    if (!seen_usable) begin
      status_c = STATUS_NO_COST;
    end else if (at_edge) begin
      status_c = STATUS_EDGE;
    end else if (not_unique) begin
      status_c = STATUS_NOT_UNIQUE;
    end else begin
      status_c = STATUS_VALID;
    end
  end

  assign sts.need_div = (status_c == STATUS_VALID);

  assign sum_c  = 17'(cost_before_best) + 17'(cost_after_best);
  assign low2_c = {lowest_cost, 1'b0};
  assign den_c  = (sum_c > low2_c) ? (sum_c - low2_c) : 17'd1;
  assign neg_c  = cost_before_best < cost_after_best;
  assign gap_c  = neg_c ? (cost_after_best - cost_before_best)
                        : (cost_before_best - cost_after_best);

  assign rem_shift    = {rem_q[RW-2:0], num_q[NW-1]};
  assign rem_ge       = rem_shift >= RW'(dsr_q);
  assign sts.div_last = (cnt_q == KW'(1));

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      den_q  <= den_c;
      mag_q  <= MW'(gap_c) << FRACTION_BITS;
      neg_q  <= neg_c;
      base_q <= BW'(cfg.disp_first) + BW'(best_index);
    end
    if (cmd.dload) begin
      num_q <= NW'(mag_q) + NW'(den_q);
      rem_q <= '0;
      dsr_q <= {den_q, 1'b0};
      cnt_q <= KW'(NW);
    end else if (cmd.step) begin
      rem_q <= rem_ge ? (rem_shift - RW'(dsr_q)) : rem_shift;
      num_q <= {num_q[NW-2:0], rem_ge};
      cnt_q <= cnt_q - KW'(1);
    end
  end

  assign base_s = XW'(base_q) << FRACTION_BITS;
  assign quot_x = XW'(num_q);

  always_comb begin
    if (neg_q) begin
      res_x = (quot_x > base_s) ? '0 : (base_s - quot_x);
    end else begin
      res_x = base_s + quot_x;
    end
    disp_fin = (res_x > XW'(COST_ALL_ONES)) ? COST_ALL_ONES : res_x[15:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_fail) begin
      out_data.disparity_q8 <= '0;
      out_data.status       <= status_c;
    end else if (cmd.out_fin) begin
      out_data.disparity_q8 <= disp_fin;
      out_data.status       <= STATUS_VALID;
    end
  end

endmodule

// ===== rtl/core/disparity_wta_subpixel.sv =====
// Winner-take-all disparity selection with subpixel refinement, top level.
// Costs: one transfer per cycle while in_ready is high; a pixel is R = range length transfers.
// Rejected pixel: the evaluation state registers the result; no cost is taken in that state.
// Valid pixel: divider gives one quotient bit per cycle over an NW-bit numerator,
// NW = max(16 + FRACTION_BITS, 17) + 1 (25 at defaults); states EVAL, DLOAD, DIV, FIN.
// Reset: synchronous rst restores register defaults and clears per-pixel state.
module disparity_wta_subpixel #(
  parameter int MAX_DISPARITIES = dwta_pkg::MAX_DISP_DEFAULT,
  parameter int FRACTION_BITS   = dwta_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dwta_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dwta_pkg::out_t              out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dwta_pkg::ADDR_W-1:0] paddr,
  input  logic [dwta_pkg::DATA_W-1:0] pwdata,
  output logic [dwta_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import dwta_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  dwta_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dwta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dwta_datapath #(
    .MAX_DISPARITIES (MAX_DISPARITIES),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== rtl/core/dwta_checker.sv =====
// Port-level checks for the disparity block, bound to the top level.
module dwta_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input dwta_pkg::out_t out_data
);
  import dwta_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != STATUS_VALID) |-> (out_data.disparity_q8 == 16'd0))
    else $error("rejected result carries a nonzero disparity");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending right after reset");

endmodule

bind disparity_wta_subpixel dwta_checker u_dwta_checker (.*);
